[rtl/lcdws_pkg.sv]
// Shared types and constants for the character-LCD write sequencer.
// No dependencies; used by every module of the block.
`default_nettype none

package lcdws_pkg;

    // Request codes carried on the action field
    typedef enum logic [2:0] {
        ACT_COMMAND = 3'd0,
        ACT_DATA    = 3'd1,
        ACT_INIT    = 3'd2,
        ACT_CURSOR  = 3'd3,
        ACT_NUMBER  = 3'd4,
        ACT_GLYPH   = 3'd5
    } action_t;

    // Configuration register indexes
    localparam logic CFG_FOUR_BIT_MODE   = 1'b0;
    localparam logic CFG_LINE_TWO_OFFSET = 1'b1;

    localparam logic [6:0] LINE_TWO_OFFSET_RESET = 7'd64;
    localparam int         GLYPH_ROW_COUNT       = 8;

    // Controller commands and characters
    localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_SET_DDRAM    = 8'h80;
    localparam logic [7:0] CMD_SET_CGRAM    = 8'h40;
    localparam logic [3:0] NIB_WAKE         = 4'h2;
    localparam logic [3:0] NIB_FUNC_4BIT    = 4'h8;
    localparam logic [7:0] CHAR_ZERO        = 8'h30;
    localparam logic [7:0] CHAR_MINUS       = 8'h2D;

    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;

    // One byte handed from the sequencer to the bus emitter
    typedef struct packed {
        logic       valid;
        logic       rs;
        logic       raw;    // single bus write even in four-bit mode
        logic       last;
        logic [7:0] value;
    } byte_req_t;

    // Commands to the binary-to-decimal unit
    typedef struct packed {
        logic load;
        logic advance;      // drop the leading digit
    } bcd_ctrl_t;

    // Status from the binary-to-decimal unit
    typedef struct packed {
        logic       conv_done;
        logic       last_digit;
        logic [3:0] lead_digit;
    } bcd_stat_t;

endpackage

`default_nettype wire

[rtl/lcdws_bcd_unit.sv]
// Iterative binary-to-BCD converter (shift and add-3), one bit per cycle,
// with a digit shifter for reading the result most significant first.
// Depends on lcdws_pkg.
`default_nettype none

module lcdws_bcd_unit #(
    parameter int NUMBER_WIDTH = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire lcdws_pkg::bcd_ctrl_t    ctrl,
    input  wire logic [NUMBER_WIDTH-1:0] magnitude,
    output lcdws_pkg::bcd_stat_t         stat
);

    localparam int DIGITS = (NUMBER_WIDTH * 3) / 10 + 1;
    localparam int BCD_W  = DIGITS * 4;
    localparam int CNT_W  = $clog2(NUMBER_WIDTH + 1);
    localparam int DIG_W  = $clog2(DIGITS + 1);

    logic [NUMBER_WIDTH-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]        bcd_reg, bcd_next;
    logic [BCD_W-1:0]        bcd_adj;
    logic [CNT_W-1:0]        bit_cnt_reg, bit_cnt_next;
    logic [DIG_W-1:0]        dig_cnt_reg, dig_cnt_next;

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ? bcd_reg[i*4 +: 4] + 4'd3
                                                            : bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        if (ctrl.load)
        begin
            bin_next     = magnitude;
            bcd_next     = '0;
            bit_cnt_next = CNT_W'(NUMBER_WIDTH);
            dig_cnt_next = DIG_W'(DIGITS);
        end
        else if (bit_cnt_reg != '0)
        begin
            {bcd_next, bin_next} = {bcd_adj, bin_reg} << 1;
            bit_cnt_next         = bit_cnt_reg - 1'b1;
        end
        else if (ctrl.advance)
        begin
            bcd_next     = bcd_reg << 4;
            dig_cnt_next = dig_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
        end
        else
        begin
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign stat.conv_done  = (bit_cnt_reg == '0);
    assign stat.last_digit = (dig_cnt_reg == DIG_W'(1));
    assign stat.lead_digit = bcd_reg[BCD_W-1 -: 4];

    // digits are only consumed once the conversion has run out of bits
    a_advance_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.advance |-> stat.conv_done)
        else $error("digit shift during conversion");

    a_load_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> !stat.conv_done)
        else $error("load did not start a conversion");

endmodule

`default_nettype wire

[rtl/lcdws_emitter.sv]
// Bus-write emitter: turns byte requests into one byte write or two nibble
// writes (high first) and holds the result in an output register.
// Depends on lcdws_pkg.
`default_nettype none

module lcdws_emitter (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 four_bit_mode,
    input  wire lcdws_pkg::byte_req_t req,
    output logic                      req_ready,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      reg_select,
    output logic [7:0]                bus_value,
    output logic                      last
);

    logic       out_valid_reg, out_valid_next;
    logic       out_rs_reg, out_rs_next;
    logic [7:0] out_value_reg, out_value_next;
    logic       out_last_reg, out_last_next;
    logic       pend_valid_reg, pend_valid_next;
    logic       pend_rs_reg, pend_rs_next;
    logic [3:0] pend_nib_reg, pend_nib_next;
    logic       pend_last_reg, pend_last_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign req_ready = slot_free && !pend_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_rs_next     = out_rs_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_rs_next    = pend_rs_reg;
        pend_nib_next   = pend_nib_reg;
        pend_last_next  = pend_last_reg;
        if (slot_free)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_rs_next     = pend_rs_reg;
                out_value_next  = {4'b0, pend_nib_reg};
                out_last_next   = pend_last_reg;
                pend_valid_next = 1'b0;
            end
            else if (req.valid)
            begin
                out_valid_next = 1'b1;
                out_rs_next    = req.rs;
                if (four_bit_mode && !req.raw)
                begin
                    out_value_next  = {4'b0, req.value[7:4]};
                    out_last_next   = 1'b0;
                    pend_valid_next = 1'b1;
                    pend_rs_next    = req.rs;
                    pend_nib_next   = req.value[3:0];
                    pend_last_next  = req.last;
                end
                else
                begin
                    out_value_next = req.value;
                    out_last_next  = req.last;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rs_reg    <= out_rs_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        pend_rs_reg   <= pend_rs_next;
        pend_nib_reg  <= pend_nib_next;
        pend_last_reg <= pend_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign reg_select = out_rs_reg;
    assign bus_value  = out_value_reg;
    assign last       = out_last_reg;

    // a held low nibble always sits behind its high nibble
    a_pend_behind_high: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("low nibble pending without high nibble");

    a_pend_only_nibbles: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> four_bit_mode)
        else $error("nibble split in eight-bit mode");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> !pend_valid_reg)
        else $error("write pending behind a final write");

endmodule

`default_nettype wire

[rtl/char_lcd_write_sequencer_unit.sv]
// Character-LCD write sequencer, top level: request sequencer and config.
// Depends on lcdws_pkg, lcdws_bcd_unit and lcdws_emitter.
//
// Usage
//   Input channel (in_valid / in_stall): one display request per word. The
//   block raises in_stall from the cycle after a word is taken until that
//   request has handed its last byte to the emitter.
//   Output channel (out_valid / out_stall): one bus write per word with
//   reg_select, bus_value and last; last marks the final write of a request.
//   The receiver may stall at any time; the word holds until taken and the
//   sequencer waits. Unused action codes are taken and give no words.
//   Config channel (cfg_valid / cfg_ready, always ready): index 0 is
//   four_bit_mode, index 1 is line_two_offset. Write only while idle.
// Timing
//   Within a request, one word per cycle while unstalled (two words per byte
//   in four-bit mode, one for each raw wake-up nibble). A number first runs
//   through the shift-add-3 converter, then drops its leading zeros, then
//   emits its sign and digits. Longest requests, in four-bit mode with
//   NUMBER_WIDTH 32: a ten-digit negative number or a glyph (22 words each).
// Reset
//   Asynchronous, active low: idle, no words held, four_bit_mode 0,
//   line_two_offset 64.
`default_nettype none

module char_lcd_write_sequencer_unit #(
    parameter int NUMBER_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  action,
    input  wire logic [7:0]  byte_value,
    input  wire logic [6:0]  column,
    input  wire logic [1:0]  row,
    input  wire logic [31:0] number_value,
    input  wire logic [2:0]  glyph_slot,
    input  wire logic [63:0] glyph_rows,
    // bus write channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             reg_select,
    output logic [7:0]       bus_value,
    output logic             last,
    // configuration channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_data
);

    // step numbers within a request
    localparam logic [3:0] INIT_STEP_FUNC    = 4'd2;  // eight-bit mode starts here
    localparam logic [3:0] INIT_STEP_DISPLAY = 4'd3;
    localparam logic [3:0] INIT_STEP_CLEAR   = 4'd4;
    localparam logic [3:0] GLYPH_STEP_CURSOR = 4'(lcdws_pkg::GLYPH_ROW_COUNT + 1);
    localparam logic [3:0] GLYPH_STEP_SLOT   = 4'(lcdws_pkg::GLYPH_ROW_COUNT + 2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t                   state_reg, state_next;
    lcdws_pkg::action_t       action_reg, action_next;
    logic [3:0]               step_reg, step_next;
    logic                     neg_reg, neg_next;
    logic [7:0]               byte_reg, byte_next;
    logic [6:0]               column_reg, column_next;
    logic [1:0]               row_reg, row_next;
    logic [2:0]               slot_reg, slot_next;
    logic [63:0]              glyph_reg, glyph_next;

    logic                     four_bit_mode_reg;
    logic [6:0]               line_two_offset_reg;

    logic [NUMBER_WIDTH-1:0]  num_bits;
    logic                     num_neg;
    logic [NUMBER_WIDTH-1:0]  num_mag;
    logic [8:0]               cursor_addr;
    logic [7:0]               cursor_cmd;

    lcdws_pkg::bcd_ctrl_t     bcd_ctrl;
    lcdws_pkg::bcd_stat_t     bcd_stat;
    lcdws_pkg::byte_req_t     step_req;
    lcdws_pkg::byte_req_t     req;
    logic                     req_ready;

    // ---------------- configuration registers ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_bit_mode_reg   <= 1'b0;
            line_two_offset_reg <= lcdws_pkg::LINE_TWO_OFFSET_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lcdws_pkg::CFG_FOUR_BIT_MODE:   four_bit_mode_reg   <= cfg_data[0];
                lcdws_pkg::CFG_LINE_TWO_OFFSET: line_two_offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- operand preparation ----------------
    // magnitude fits NUMBER_WIDTH unsigned bits, even for the most negative value
    assign num_bits = number_value[NUMBER_WIDTH-1:0];
    assign num_neg  = num_bits[NUMBER_WIDTH-1];
    assign num_mag  = num_neg ? NUMBER_WIDTH'(-num_bits) : num_bits;

    // DDRAM address wraps within seven bits; bit 7 is the command bit
    assign cursor_addr = 9'(row_reg) * 9'(line_two_offset_reg) + 9'(column_reg);
    assign cursor_cmd  = lcdws_pkg::CMD_SET_DDRAM | {1'b0, cursor_addr[6:0]};

    // ---------------- byte for the current step ----------------
    always_comb
    begin
        step_req       = '0;
        step_req.valid = (state_reg == ST_EMIT);
        step_req.rs    = lcdws_pkg::RS_COMMAND;
        case (action_reg)
            lcdws_pkg::ACT_COMMAND:
            begin
                step_req.value = byte_reg;
                step_req.last  = 1'b1;
            end
            lcdws_pkg::ACT_DATA:
            begin
                step_req.rs    = lcdws_pkg::RS_DATA;
                step_req.value = byte_reg;
                step_req.last  = 1'b1;
            end
            lcdws_pkg::ACT_INIT:
            begin
                // four-bit mode opens with single wake-up nibbles
                case (step_reg)
                    INIT_STEP_FUNC:
                    begin
                        step_req.raw   = four_bit_mode_reg;
                        step_req.value = four_bit_mode_reg ? {4'b0, lcdws_pkg::NIB_FUNC_4BIT}
                                                           : lcdws_pkg::CMD_FUNCTION_SET;
                    end
                    INIT_STEP_DISPLAY: step_req.value = lcdws_pkg::CMD_DISPLAY_ON;
                    INIT_STEP_CLEAR:
                    begin
                        step_req.value = lcdws_pkg::CMD_CLEAR;
                        step_req.last  = 1'b1;
                    end
                    default:
                    begin
                        step_req.raw   = 1'b1;
                        step_req.value = {4'b0, lcdws_pkg::NIB_WAKE};
                    end
                endcase
            end
            lcdws_pkg::ACT_CURSOR:
            begin
                step_req.value = cursor_cmd;
                step_req.last  = 1'b1;
            end
            lcdws_pkg::ACT_NUMBER:
            begin
                step_req.rs = lcdws_pkg::RS_DATA;
                if (step_reg == '0)
                begin
                    step_req.value = lcdws_pkg::CHAR_MINUS;
                end
                else
                begin
                    step_req.value = lcdws_pkg::CHAR_ZERO | {4'b0, bcd_stat.lead_digit};
                    step_req.last  = bcd_stat.last_digit;
                end
            end
            lcdws_pkg::ACT_GLYPH:
            begin
                if (step_reg == '0)
                begin
                    step_req.value = lcdws_pkg::CMD_SET_CGRAM | {2'b0, slot_reg, 3'b0};
                end
                else if (step_reg == GLYPH_STEP_CURSOR)
                begin
                    step_req.value = cursor_cmd;
                end
                else if (step_reg == GLYPH_STEP_SLOT)
                begin
                    step_req.rs    = lcdws_pkg::RS_DATA;
                    step_req.value = {5'b0, slot_reg};
                    step_req.last  = 1'b1;
                end
                else
                begin
                    step_req.rs    = lcdws_pkg::RS_DATA;
                    step_req.value = glyph_reg[7:0];
                end
            end
            default:
            begin
                step_req.valid = 1'b0;
            end
        endcase
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next  = state_reg;
        action_next = action_reg;
        step_next   = step_reg;
        neg_next    = neg_reg;
        byte_next   = byte_reg;
        column_next = column_reg;
        row_next    = row_reg;
        slot_next   = slot_reg;
        glyph_next  = glyph_reg;
        bcd_ctrl    = '0;
        req         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    action_next = lcdws_pkg::action_t'(action);
                    byte_next   = byte_value;
                    column_next = column;
                    row_next    = row;
                    slot_next   = glyph_slot;
                    glyph_next  = glyph_rows;
                    neg_next    = num_neg;
                    step_next   = '0;
                    case (lcdws_pkg::action_t'(action))
                        lcdws_pkg::ACT_NUMBER:
                        begin
                            bcd_ctrl.load = 1'b1;
                            state_next    = ST_CONVERT;
                        end
                        lcdws_pkg::ACT_INIT:
                        begin
                            step_next  = four_bit_mode_reg ? 4'd0 : INIT_STEP_FUNC;
                            state_next = ST_EMIT;
                        end
                        lcdws_pkg::ACT_COMMAND,
                        lcdws_pkg::ACT_DATA,
                        lcdws_pkg::ACT_CURSOR,
                        lcdws_pkg::ACT_GLYPH:
                        begin
                            state_next = ST_EMIT;
                        end
                        default: ;  // no bus writes
                    endcase
                end
            end
            ST_CONVERT:
            begin
                if (bcd_stat.conv_done)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, keep at least one digit
                if (bcd_stat.lead_digit == 4'd0 && !bcd_stat.last_digit)
                begin
                    bcd_ctrl.advance = 1'b1;
                end
                else
                begin
                    step_next  = neg_reg ? 4'd0 : 4'd1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                req = step_req;
                if (req_ready)
                begin
                    step_next = step_reg + 4'd1;
                    if (action_reg == lcdws_pkg::ACT_GLYPH && step_reg != '0)
                    begin
                        glyph_next = glyph_reg >> 8;
                    end
                    if (action_reg == lcdws_pkg::ACT_NUMBER && step_reg != '0)
                    begin
                        bcd_ctrl.advance = 1'b1;
                    end
                    if (step_req.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            action_reg <= lcdws_pkg::ACT_COMMAND;
            step_reg   <= '0;
            neg_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            action_reg <= action_next;
            step_reg   <= step_next;
            neg_reg    <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        column_reg <= column_next;
        row_reg    <= row_next;
        slot_reg   <= slot_next;
        glyph_reg  <= glyph_next;
    end

    assign in_stall = (state_reg != ST_IDLE);

    // ---------------- datapath units ----------------
    lcdws_bcd_unit #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_bcd (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (bcd_ctrl),
        .magnitude (num_mag),
        .stat      (bcd_stat)
    );

    lcdws_emitter u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .four_bit_mode (four_bit_mode_reg),
        .req           (req),
        .req_ready     (req_ready),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .reg_select    (reg_select),
        .bus_value     (bus_value),
        .last          (last)
    );

    // digits are only emitted from a finished conversion
    a_digits_converted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && action_reg == lcdws_pkg::ACT_NUMBER && step_reg != '0)
        |-> bcd_stat.conv_done)
        else $error("digit emitted before conversion finished");

endmodule

`default_nettype wire
